>>> rtl/sdik_pkg.sv
// Shared types, constants and tables for the swerve drive inverse kinematics block.
package sdik_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int SQRT_STEPS    = 18;
    localparam int LANE_STAGES   = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int STEP_W        = $clog2(LANE_STAGES);
    localparam int WHEELS        = 4;

    localparam int VEL_W   = 16;
    localparam int SCALE_W = 16;
    localparam int PROD_W  = 33;
    localparam int P_W     = 21;
    localparam int SUM_W   = 22;
    localparam int TERM_W  = 18;
    localparam int RAD_W   = 36;
    localparam int REM_W   = 20;
    localparam int ROOT_W  = 18;
    localparam int CX_W    = 33;
    localparam int Z_W     = 25;
    localparam int HEAD_W  = 16;
    localparam int SPEED_W = 18;
    localparam int ANG_SHIFT = 12;

    localparam logic signed [HEAD_W-1:0] HALF_TURN    = 16'sd18000;
    localparam logic signed [HEAD_W-1:0] QUARTER_TURN = 16'sd9000;
    localparam logic signed [Z_W-1:0]    HALF_TURN_Z  = 25'sd4608000;
    localparam logic [SPEED_W-1:0]       SPEED_MAX    = 18'd185364;

    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_ROTATION_SCALE = 1'b0;
    localparam logic [SCALE_W-1:0] ROTATION_SCALE_RESET = 16'd4096;

    typedef struct packed {
        logic signed [VEL_W-1:0] x_velocity;
        logic signed [VEL_W-1:0] y_velocity;
        logic signed [VEL_W-1:0] turn_rate;
    } sdik_in_t;

    typedef struct packed {
        logic [SPEED_W-1:0]       front_left_speed;
        logic [SPEED_W-1:0]       front_right_speed;
        logic [SPEED_W-1:0]       rear_left_speed;
        logic [SPEED_W-1:0]       rear_right_speed;
        logic signed [HEAD_W-1:0] front_left_heading;
        logic signed [HEAD_W-1:0] front_right_heading;
        logic signed [HEAD_W-1:0] rear_left_heading;
        logic signed [HEAD_W-1:0] rear_right_heading;
    } sdik_out_t;

    // one wheel's work in flight: square root remainder/root and CORDIC vector/angle
    typedef struct packed {
        logic [RAD_W-1:0]         rad;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic signed [CX_W-1:0]   cx;
        logic signed [CX_W-1:0]   cy;
        logic signed [Z_W-1:0]    cz;
        logic                     special;
        logic signed [HEAD_W-1:0] special_heading;
    } sdik_lane_t;

    typedef sdik_lane_t [WHEELS-1:0] sdik_row_t;

    // atan(2^-i) in units of 1/25600 degree
    function automatic logic signed [Z_W-1:0] sdik_atan(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] t;
        case (i)
            5'd0:  t = 25'sd1152000;
            5'd1:  t = 25'sd680065;
            5'd2:  t = 25'sd359328;
            5'd3:  t = 25'sd182400;
            5'd4:  t = 25'sd91554;
            5'd5:  t = 25'sd45822;
            5'd6:  t = 25'sd22916;
            5'd7:  t = 25'sd11459;
            5'd8:  t = 25'sd5730;
            5'd9:  t = 25'sd2865;
            5'd10: t = 25'sd1432;
            5'd11: t = 25'sd716;
            5'd12: t = 25'sd358;
            5'd13: t = 25'sd179;
            5'd14: t = 25'sd90;
            5'd15: t = 25'sd45;
            5'd16: t = 25'sd22;
            5'd17: t = 25'sd11;
            5'd18: t = 25'sd6;
            5'd19: t = 25'sd3;
            5'd20: t = 25'sd1;
            5'd21: t = 25'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic signed [TERM_W-1:0] sdik_sat(input logic signed [SUM_W-1:0] v);
        logic signed [TERM_W-1:0] r;
        if (v > 22'sd131071) begin
            r = 18'sd131071;
        end else if (v < -22'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[TERM_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/swerve_drive_inverse_kinematics_top.sv
// Top level of the four-wheel swerve drive inverse kinematics block.
// Takes one body command per cycle unless m_ready back-pressure fills the pipe, and
// returns one request with the speed and steering heading of all four wheels. It has
// five front stages, one chain cell per square root digit or CORDIC rotation (16 CORDIC
// stages by default), whichever chain is longer, and one output stage. Every stage is an
// elastic register, so the pipe keeps filling while a finished result waits on m_ready.
// rotation_scale sits at byte address 0 of the register port and resets to 1.0 (Q4.12).
module swerve_drive_inverse_kinematics_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdik_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sdik_pkg::sdik_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sdik_pkg::sdik_out_t           m_data
);
    import sdik_pkg::*;

    logic [SCALE_W-1:0] rot_scale_reg;
    logic               reg_sel;

    logic [LANE_STAGES:0] chain_valid;
    logic [LANE_STAGES:0] chain_ready;
    sdik_row_t            chain_row [LANE_STAGES+1];

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_ROTATION_SCALE);
    assign prdata  = reg_sel ? {{(32-SCALE_W){1'b0}}, rot_scale_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_scale_reg <= ROTATION_SCALE_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            rot_scale_reg <= pwdata[SCALE_W-1:0];
        end
    end

    sdik_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rot_scale (rot_scale_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .dn_valid  (chain_valid[0]),
        .dn_ready  (chain_ready[0]),
        .dn_row    (chain_row[0])
    );

    for (genvar k = 0; k < LANE_STAGES; k++) begin : g_cell
        sdik_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step     (STEP_W'(k)),
            .up_valid (chain_valid[k]),
            .up_ready (chain_ready[k]),
            .up_row   (chain_row[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_ready (chain_ready[k+1]),
            .dn_row   (chain_row[k+1])
        );
    end

    sdik_finish u_finish (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (chain_valid[LANE_STAGES]),
        .up_ready (chain_ready[LANE_STAGES]),
        .up_row   (chain_row[LANE_STAGES]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // an empty output stage must let the whole chain take a new request
    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.front_left_speed <= SPEED_MAX) &&
                    (m_data.front_right_speed <= SPEED_MAX) &&
                    (m_data.rear_left_speed <= SPEED_MAX) &&
                    (m_data.rear_right_speed <= SPEED_MAX))
        else $error("wheel speed out of range");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.front_left_heading >= -HALF_TURN) &&
                    (m_data.front_left_heading <= HALF_TURN) &&
                    (m_data.front_right_heading >= -HALF_TURN) &&
                    (m_data.front_right_heading <= HALF_TURN) &&
                    (m_data.rear_left_heading >= -HALF_TURN) &&
                    (m_data.rear_left_heading <= HALF_TURN) &&
                    (m_data.rear_right_heading >= -HALF_TURN) &&
                    (m_data.rear_right_heading <= HALF_TURN))
        else $error("wheel heading out of range");

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && reg_sel) |=> rot_scale_reg == $past(pwdata[SCALE_W-1:0]))
        else $error("rotation scale write lost");

endmodule

>>> rtl/sdik_front.sv
// Front stages: register request, turn product, saturated terms, squares and CORDIC set-up, square sums.
module sdik_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [sdik_pkg::SCALE_W-1:0]    rot_scale,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sdik_pkg::sdik_in_t              s_data,
    output logic                            dn_valid,
    input  logic                            dn_ready,
    output sdik_pkg::sdik_row_t             dn_row
);
    import sdik_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] adv;
    logic [NSTG-1:0] load;

    sdik_in_t                 in_reg;
    logic signed [VEL_W-1:0]  x1_reg, y1_reg;
    logic signed [PROD_W-1:0] prod1_reg, prod1_next;
    logic signed [TERM_W-1:0] ta_reg, tb_reg, tc_reg, td_reg;
    logic signed [TERM_W-1:0] ta_next, tb_next, tc_next, td_next;
    sdik_row_t                row3_reg, row3_next;
    logic [RAD_W-1:0]         sqa_reg [WHEELS];
    logic [RAD_W-1:0]         sqb_reg [WHEELS];
    logic [RAD_W-1:0]         sqa_next [WHEELS];
    logic [RAD_W-1:0]         sqb_next [WHEELS];
    sdik_row_t                row4_reg, row4_next;

    always_comb begin
        for (int k = NSTG - 1; k >= 0; k--) begin
            if (k == NSTG - 1) begin
                adv[k] = !valid_reg[k] || dn_ready;
            end else begin
                adv[k] = !valid_reg[k] || adv[k+1];
            end
        end
        load[0] = adv[0] && s_valid;
        for (int k = 1; k < NSTG; k++) begin
            load[k] = adv[k] && valid_reg[k-1];
        end
    end

    assign s_ready  = adv[0];
    assign dn_valid = valid_reg[NSTG-1];
    assign dn_row   = row4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg[0] <= adv[0] ? s_valid : valid_reg[0];
            for (int k = 1; k < NSTG; k++) begin
                valid_reg[k] <= adv[k] ? valid_reg[k-1] : valid_reg[k];
            end
        end
    end

    assign prod1_next = in_reg.turn_rate * $signed({1'b0, rot_scale});

    always_comb begin
        logic signed [PROD_W:0]   p_full;
        logic signed [P_W-1:0]    p;
        logic signed [SUM_W-1:0]  xe, ye, pe;
        p_full  = ($signed({prod1_reg[PROD_W-1], prod1_reg}) + 34'sd2048) >>> 12;
        p       = p_full[P_W-1:0];
        xe      = SUM_W'(x1_reg);
        ye      = SUM_W'(y1_reg);
        pe      = SUM_W'(p);
        ta_next = sdik_sat(xe - pe);
        tb_next = sdik_sat(xe + pe);
        tc_next = sdik_sat(ye - pe);
        td_next = sdik_sat(ye + pe);
    end

    // pairs (first, second): front left (B,C), front right (B,D), rear left (A,C), rear right (A,D)
    always_comb begin
        logic signed [TERM_W-1:0]   fa [WHEELS];
        logic signed [TERM_W-1:0]   fb [WHEELS];
        logic signed [2*TERM_W-1:0] sq_a, sq_b;
        logic signed [CX_W-1:0]     ax, bx;
        fa[0] = tb_reg; fb[0] = tc_reg;
        fa[1] = tb_reg; fb[1] = td_reg;
        fa[2] = ta_reg; fb[2] = tc_reg;
        fa[3] = ta_reg; fb[3] = td_reg;
        for (int w = 0; w < WHEELS; w++) begin
            sq_a        = fa[w] * fa[w];
            sq_b        = fb[w] * fb[w];
            sqa_next[w] = sq_a[RAD_W-1:0];
            sqb_next[w] = sq_b[RAD_W-1:0];
            ax = {{(CX_W-TERM_W-ANG_SHIFT){fa[w][TERM_W-1]}}, fa[w], {ANG_SHIFT{1'b0}}};
            bx = {{(CX_W-TERM_W-ANG_SHIFT){fb[w][TERM_W-1]}}, fb[w], {ANG_SHIFT{1'b0}}};
            row3_next[w].rad  = '0;
            row3_next[w].rem  = '0;
            row3_next[w].root = '0;
            if (fb[w] < 0) begin
                row3_next[w].cx = -bx;
                row3_next[w].cy = -ax;
                row3_next[w].cz = (fa[w] > 0) ? HALF_TURN_Z : -HALF_TURN_Z;
            end else begin
                row3_next[w].cx = bx;
                row3_next[w].cy = ax;
                row3_next[w].cz = '0;
            end
            row3_next[w].special = (fa[w] == '0) || (fb[w] == '0);
            if (fa[w] == '0) begin
                row3_next[w].special_heading = (fb[w] < 0) ? HALF_TURN : '0;
            end else begin
                row3_next[w].special_heading = (fa[w] > 0) ? QUARTER_TURN : -QUARTER_TURN;
            end
        end
    end

    always_comb begin
        row4_next = row3_reg;
        for (int w = 0; w < WHEELS; w++) begin
            row4_next[w].rad = sqa_reg[w] + sqb_reg[w];
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            in_reg <= s_data;
        end
        if (load[1]) begin
            x1_reg    <= in_reg.x_velocity;
            y1_reg    <= in_reg.y_velocity;
            prod1_reg <= prod1_next;
        end
        if (load[2]) begin
            ta_reg <= ta_next;
            tb_reg <= tb_next;
            tc_reg <= tc_next;
            td_reg <= td_next;
        end
        if (load[3]) begin
            row3_reg <= row3_next;
            sqa_reg  <= sqa_next;
            sqb_reg  <= sqb_next;
        end
        if (load[4]) begin
            row4_reg <= row4_next;
        end
    end

endmodule

>>> rtl/sdik_cell.sv
// One chain cell: per wheel a root digit and a CORDIC turn if step < CORDIC_STAGES.
module sdik_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sdik_pkg::STEP_W-1:0]  step,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  sdik_pkg::sdik_row_t          up_row,
    output logic                         dn_valid,
    input  logic                         dn_ready,
    output sdik_pkg::sdik_row_t          dn_row
);
    import sdik_pkg::*;

    logic      valid_reg;
    sdik_row_t row_reg, row_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_row   = row_reg;

    always_comb begin
        logic [REM_W+1:0]       rem_sh, trial;
        logic signed [CX_W-1:0] xs, ys;
        logic signed [Z_W-1:0]  t;
        row_next = up_row;
        t        = sdik_atan(step);
        for (int w = 0; w < WHEELS; w++) begin
            rem_sh = {up_row[w].rem, up_row[w].rad[RAD_W-1 -: 2]};
            trial  = {2'b00, up_row[w].root, 2'b01};
            xs     = up_row[w].cx >>> step;
            ys     = up_row[w].cy >>> step;
            if (step < SQRT_STEPS) begin
                row_next[w].rad = {up_row[w].rad[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    row_next[w].rem  = REM_W'(rem_sh - trial);
                    row_next[w].root = {up_row[w].root[ROOT_W-2:0], 1'b1};
                end else begin
                    row_next[w].rem  = rem_sh[REM_W-1:0];
                    row_next[w].root = {up_row[w].root[ROOT_W-2:0], 1'b0};
                end
            end
            if (step < CORDIC_STAGES && step < ATAN_LEN) begin
                // rotate toward the x axis
                if (up_row[w].cy > 0) begin
                    row_next[w].cx = up_row[w].cx + ys;
                    row_next[w].cy = up_row[w].cy - xs;
                    row_next[w].cz = up_row[w].cz + t;
                end else begin
                    row_next[w].cx = up_row[w].cx - ys;
                    row_next[w].cy = up_row[w].cy + xs;
                    row_next[w].cz = up_row[w].cz - t;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            row_reg <= row_next;
        end
    end

endmodule

>>> rtl/sdik_finish.sv
// Output stage: round the roots, scale and clamp the angles or take the special heading, hold the result request.
module sdik_finish (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  sdik_pkg::sdik_row_t  up_row,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sdik_pkg::sdik_out_t  m_data
);
    import sdik_pkg::*;

    logic      valid_reg;
    sdik_out_t data_reg, data_next;

    assign up_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        logic [SPEED_W-1:0]       spd [WHEELS];
        logic signed [HEAD_W-1:0] hdg [WHEELS];
        logic signed [Z_W:0]      zr;
        logic signed [Z_W-8:0]    h;
        for (int w = 0; w < WHEELS; w++) begin
            spd[w] = up_row[w].root;
            if (up_row[w].rem > {{(REM_W-ROOT_W){1'b0}}, up_row[w].root}) begin
                spd[w] = up_row[w].root + 1'b1;
            end
            zr = ($signed({up_row[w].cz[Z_W-1], up_row[w].cz}) + 26'sd128) >>> 8;
            h  = zr[Z_W-8:0];
            if (up_row[w].special) begin
                hdg[w] = up_row[w].special_heading;
            end else if (h > $signed({{(Z_W-7-HEAD_W){1'b0}}, HALF_TURN})) begin
                hdg[w] = HALF_TURN;
            end else if (h < -$signed({{(Z_W-7-HEAD_W){1'b0}}, HALF_TURN})) begin
                hdg[w] = -HALF_TURN;
            end else begin
                hdg[w] = h[HEAD_W-1:0];
            end
        end
        data_next.front_left_speed    = spd[0];
        data_next.front_right_speed   = spd[1];
        data_next.rear_left_speed     = spd[2];
        data_next.rear_right_speed    = spd[3];
        data_next.front_left_heading  = hdg[0];
        data_next.front_right_heading = hdg[1];
        data_next.rear_left_heading   = hdg[2];
        data_next.rear_right_heading  = hdg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> tb/sv/swerve_drive_inverse_kinematics_top_test.sv
// Self-checking testbench for the swerve drive inverse kinematics block.
module swerve_drive_inverse_kinematics_top_test;
    import sdik_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    sdik_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sdik_out_t m_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    logic [SCALE_W-1:0] scale_q = ROTATION_SCALE_RESET;
    sdik_out_t wheel_queue[$];

    localparam int LATENCY = 24;
    localparam longint ATAN_T[24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
        11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};

    always #6 aclk = ~aclk;

    swerve_drive_inverse_kinematics_top dut (.*);

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp18(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic logic [SPEED_W-1:0] magnitude(longint a, longint b);
        longint unsigned s, r, bitv;
        longint unsigned s0;
        s = a * a + b * b;
        s0 = s;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= r + bitv) begin
                s -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        if (s0 - r * r > r) r++;
        return r[SPEED_W-1:0];
    endfunction

    function automatic logic signed [HEAD_W-1:0] bearing(longint a, longint b);
        longint x, y, z, xs, ys, h;
        z = 0;
        if (a == 0) return (b < 0) ? 16'sd18000 : 16'sd0;
        if (b == 0) return (a > 0) ? 16'sd9000 : -16'sd9000;
        x = b * 4096;
        y = a * 4096;
        if (b < 0) begin
            x = -x;
            y = -y;
            z = (a > 0) ? 4608000 : -4608000;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += ATAN_T[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_T[i];
            end
        end
        h = floor_shr(z + 128, 8);
        if (h > 18000) h = 18000;
        if (h < -18000) h = -18000;
        return h[HEAD_W-1:0];
    endfunction

    function automatic sdik_out_t wheel_predict(sdik_in_t cmd);
        sdik_out_t r;
        longint p, ta, tb, tc, td;
        p = floor_shr(longint'(cmd.turn_rate) * longint'(scale_q) + 2048, 12);
        ta = clamp18(longint'(cmd.x_velocity) - p);
        tb = clamp18(longint'(cmd.x_velocity) + p);
        tc = clamp18(longint'(cmd.y_velocity) - p);
        td = clamp18(longint'(cmd.y_velocity) + p);
        r.front_left_speed = magnitude(tb, tc);
        r.front_right_speed = magnitude(tb, td);
        r.rear_left_speed = magnitude(ta, tc);
        r.rear_right_speed = magnitude(ta, td);
        r.front_left_heading = bearing(tb, tc);
        r.front_right_heading = bearing(tb, td);
        r.rear_left_heading = bearing(ta, tc);
        r.rear_right_heading = bearing(ta, td);
        return r;
    endfunction

    // receiver stall pattern
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        sdik_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (wheel_queue.size() == 0) begin
                $display("%0t: unexpected request %h", $time, m_data);
                error_count++;
            end else begin
                want = wheel_queue.pop_front();
                if (want !== m_data) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, m_data);
                    error_count++;
                end
            end
        end
    end

    task automatic write_scale(logic [SCALE_W-1:0] v);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {REG_ROTATION_SCALE, 2'b00}; pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        scale_q = v;
    endtask

    // valid stays high after acceptance until the next request, an idle cycle or a drain
    task automatic send_command(sdik_in_t cmd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= cmd;
        wheel_queue.push_back(wheel_predict(cmd));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (wheel_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic sdik_in_t rand_command();
        sdik_in_t c;
        c.x_velocity = 16'($urandom);
        c.y_velocity = 16'($urandom);
        c.turn_rate = 16'($urandom);
        // bias some fields to small or zero values to hit the axis cases
        if ($urandom_range(7) == 0) c.x_velocity = '0;
        if ($urandom_range(7) == 0) c.y_velocity = '0;
        if ($urandom_range(5) == 0) c.turn_rate = '0;
        if ($urandom_range(3) == 0) c.turn_rate = 16'(int'($urandom_range(0, 400)) - 200);
        return c;
    endfunction

    task automatic test_directed();
        sdik_in_t c;
        logic signed [15:0] v[6] = '{16'sh8000, 16'sh7fff, 0, 1, -1, 100};
        for (int i = 0; i < 6; i++) begin
            c.x_velocity = v[i];
            c.y_velocity = v[(i + 2) % 6];
            c.turn_rate = v[(i + 4) % 6];
            send_command(c);
        end
        c = '{16'sd0, 16'sd0, 16'sd0};       send_command(c);
        c = '{16'sd500, -16'sd500, 16'sd0};  send_command(c);
        c = '{-16'sd500, 16'sd0, 16'sd0};    send_command(c);
        c = '{16'sd0, -16'sd700, 16'sd0};    send_command(c);
        c = '{16'sh7fff, 16'sh7fff, 16'sh7fff}; send_command(c);
        c = '{16'sh8000, 16'sh8000, 16'sh8000}; send_command(c);
        c = '{16'sd0, 16'sd0, 16'sd300};     send_command(c);
        c = '{16'sd0, 16'sd0, -16'sd300};    send_command(c);
        drain();
    endtask

    task automatic test_scale(logic [SCALE_W-1:0] sc, int n, int idle, int stall);
        write_scale(sc);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) send_command(rand_command());
        drain();
    endtask

    task automatic test_pause();
        send_idle_pct = 0;
        recv_stall_pct = 53;
        repeat (40) send_command(rand_command());
        // hold until the pipe is empty, then resume
        s_valid <= 1'b0;
        while (wheel_queue.size() != 0) @(posedge aclk);
        repeat (40) send_command(rand_command());
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_scale(16'd0, 120, 0, 0);
        test_scale(16'hffff, 300, 53, 0);
        test_scale(16'd4096, 300, 0, 53);
        test_scale(16'd1234, 300, 10, 10);
        test_scale(16'd8192, 300, 0, 0);
        test_scale(16'($urandom), 300, 53, 53);
        test_pause();
        if (error_count == 0) begin
            $display("swerve_drive_inverse_kinematics_top_test: done, clean");
        end else begin
            $display("swerve_drive_inverse_kinematics_top_test: done, errors");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("swerve_drive_inverse_kinematics_top_test: done, errors");
        $finish;
    end
endmodule
